FILE: rtl/swx_pkg.sv
// shared constants, codes and types of the sliding window extremum detector
package swx_pkg;

  localparam int MAX_HALF_WINDOW = 15;
  localparam int HALF_BITS       = 4;
  localparam int RING_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
  localparam int SLOT_BITS       = $clog2(RING_DEPTH + 1);
  localparam int PRICE_BITS      = 32;
  localparam int STAMP_BITS      = 64;
  localparam int VERDICT_BITS    = 2;

  localparam logic [VERDICT_BITS-1:0] VERDICT_REGULAR = 2'd0;
  localparam logic [VERDICT_BITS-1:0] VERDICT_MINIMA  = 2'd1;
  localparam logic [VERDICT_BITS-1:0] VERDICT_MAXIMA  = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic start;
    logic cmp_en;
  } judge_ctrl_t;

endpackage

FILE: rtl/sliding_window_extremum_detector.sv
// top level: ring control, scan sequencer and output register of the extremum detector
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  kind, price, stamp
//  out      source     out_valid/out_ready  verdict, price_out, stamp_out
//  cfg      sink       cfg_we (no wait)     cfg_data (half_window)
//
// a price tick that brings the ring to half_window+1 prices or more starts a
// scan of all held prices: the ring memory read port scans one entry a cycle
// a clear transaction, or a tick below the reporting level, starts no scan
// rst is synchronous: half_window to 1, ring empty, no result pending
// a held result does not stop the next transaction being taken; only the
// final stage of a scan waits for the output register to be free
module sliding_window_extremum_detector
  import swx_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  // input transactions
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic signed [PRICE_BITS-1:0]   price,
  input  logic signed [STAMP_BITS-1:0]   stamp,
  // result transactions
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [VERDICT_BITS-1:0]        verdict,
  output logic signed [PRICE_BITS-1:0]   price_out,
  output logic signed [STAMP_BITS-1:0]   stamp_out,
  // configuration
  input  logic                           cfg_we,
  input  logic [HALF_BITS-1:0]           cfg_data
);

  localparam int ADDR_BITS = $clog2(RING_DEPTH);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [HALF_BITS-1:0]         half_window;
  logic [SLOT_BITS-1:0]         fill;
  logic [SLOT_BITS-1:0]         oldest;
  logic [SLOT_BITS-1:0]         idx;
  logic                         cmp_pend;
  logic signed [PRICE_BITS-1:0] price_hold;
  logic signed [STAMP_BITS-1:0] stamp_hold;

  logic                         accept;
  logic                         tick;
  logic [SLOT_BITS-1:0]         cap;
  logic [SLOT_BITS-1:0]         fill_next;
  logic [SLOT_BITS-1:0]         oldest_next;
  logic [SLOT_BITS-1:0]         wslot;
  logic                         report;
  logic                         out_free;
  logic [PRICE_BITS-1:0]        ram_rdata;
  logic [VERDICT_BITS-1:0]      judged;
  logic [HALF_BITS-1:0]         half_clamped;
  judge_ctrl_t                  jctrl;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (kind == KIND_TICK);
  assign out_free = !out_valid || out_ready;

  // ring capacity 2*half_window+1
  assign cap = {half_window, 1'b1};

  // while the ring is filling, the oldest slot stays at 0, so the held prices
  // are always slots 0 to fill-1
  always_comb begin
    if (fill < cap) begin
      wslot       = fill;
      fill_next   = fill + 1'b1;
      oldest_next = oldest;
    end else begin
      wslot       = oldest;
      fill_next   = fill;
      oldest_next = (oldest + 1'b1 >= cap) ? '0 : oldest + 1'b1;
    end
  end

  // reporting starts at half_window+1 prices
  assign report = (fill_next > SLOT_BITS'(half_window));

  // clamp of the written window size
  always_comb begin
    priority if (cfg_data == '0) begin
      half_clamped = HALF_BITS'(1);
    end else if (cfg_data > HALF_BITS'(MAX_HALF_WINDOW)) begin
      half_clamped = HALF_BITS'(MAX_HALF_WINDOW);
    end else begin
      half_clamped = cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick && report) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == fill - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      half_window <= HALF_BITS'(1);
      fill        <= '0;
      oldest      <= '0;
      idx         <= '0;
      cmp_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      cmp_pend <= (state == ST_SCAN);
      if (cfg_we) begin
        // a new window size empties the ring
        half_window <= half_clamped;
        fill        <= '0;
        oldest      <= '0;
      end else if (accept && kind == KIND_CLEAR) begin
        fill   <= '0;
        oldest <= '0;
      end else if (tick) begin
        fill   <= fill_next;
        oldest <= oldest_next;
      end
      if (state == ST_SCAN) begin
        idx <= idx + 1'b1;
      end else begin
        idx <= '0;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the transaction being judged and of the result
  always_ff @(posedge clk) begin
    if (tick) begin
      price_hold <= price;
      stamp_hold <= stamp;
    end
    if (state == ST_FINISH && out_free) begin
      verdict   <= judged;
      price_out <= price_hold;
      stamp_out <= stamp_hold;
    end
  end

  swx_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (tick),
    .waddr (wslot[ADDR_BITS-1:0]),
    .wdata (price),
    .re    (state == ST_SCAN),
    .raddr (idx[ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign jctrl.start  = tick;
  assign jctrl.cmp_en = cmp_pend;

  swx_judge u_judge (
    .clk     (clk),
    .ctrl    (jctrl),
    .now     (price_hold),
    .past    ($signed(ram_rdata)),
    .verdict (judged)
  );

endmodule

FILE: rtl/swx_ram.sv
// generic single write, single read ram with registered read data
module swx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/swx_judge.sv
// shared signed compare unit that accumulates the minimum and maximum flags
module swx_judge
  import swx_pkg::*;
(
  input  logic                         clk,
  input  judge_ctrl_t                  ctrl,
  input  logic signed [PRICE_BITS-1:0] now,
  input  logic signed [PRICE_BITS-1:0] past,
  output logic [VERDICT_BITS-1:0]      verdict
);

  logic is_min;
  logic is_max;

  // equal prices leave both flags alone
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      is_min <= 1'b1;
      is_max <= 1'b1;
    end else if (ctrl.cmp_en) begin
      if (past < now) begin
        is_min <= 1'b0;
      end
      if (past > now) begin
        is_max <= 1'b0;
      end
    end
  end

  always_comb begin
    priority if (is_min) begin
      verdict = VERDICT_MINIMA;
    end else if (is_max) begin
      verdict = VERDICT_MAXIMA;
    end else begin
      verdict = VERDICT_REGULAR;
    end
  end

endmodule

FILE: tb/swx_scoreboard_pkg.sv
`timescale 1ns / 100ps
// scoreboard class for the extremum detector testbench: window predictor and result checks
package swx_scoreboard_pkg;
  import swx_pkg::*;

  typedef struct {
    logic [VERDICT_BITS-1:0]      verdict;
    logic signed [PRICE_BITS-1:0] price;
    logic signed [STAMP_BITS-1:0] stamp;
  } judged_tick_t;

  class swx_scoreboard;
    logic [HALF_BITS-1:0]         half_window;
    logic signed [PRICE_BITS-1:0] window [RING_DEPTH];
    int unsigned                  oldest;
    int unsigned                  held;
    judged_tick_t                 awaited_verdicts [$];
    int unsigned                  errors;
    int unsigned                  ticks;
    int unsigned                  clears;
    int unsigned                  checked;
    int unsigned                  seen_minima;
    int unsigned                  seen_maxima;
    int unsigned                  seen_regular;

    function new();
      half_window  = HALF_BITS'(1);
      oldest       = 0;
      held         = 0;
      errors       = 0;
      ticks        = 0;
      clears       = 0;
      checked      = 0;
      seen_minima  = 0;
      seen_maxima  = 0;
      seen_regular = 0;
    endfunction

    // a write clamps to 1..MAX_HALF_WINDOW and empties the ring
    function void set_half_window(input logic [HALF_BITS-1:0] value);
      if (value == 0)
        half_window = HALF_BITS'(1);
      else if (value > MAX_HALF_WINDOW)
        half_window = HALF_BITS'(MAX_HALF_WINDOW);
      else
        half_window = value;
      oldest = 0;
      held   = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_verdicts.size();
    endfunction

    // push one accepted transaction through the window and queue its verdict, if any
    function void note_transaction(input logic kind,
                                   input logic signed [PRICE_BITS-1:0] price,
                                   input logic signed [STAMP_BITS-1:0] stamp);
      int unsigned  cap;
      int unsigned  slot;
      int unsigned  k;
      bit           is_min;
      bit           is_max;
      judged_tick_t res;
      if (kind == KIND_CLEAR) begin
        clears++;
        oldest = 0;
        held   = 0;
        return;
      end
      ticks++;
      cap  = 2 * half_window + 1;
      slot = oldest + held;
      if (slot >= cap)
        slot -= cap;
      window[slot] = price;
      if (held < cap)
        held++;
      else begin
        oldest++;
        if (oldest >= cap)
          oldest = 0;
      end
      if (held < half_window + 1)
        return;
      is_min = 1'b1;
      is_max = 1'b1;
      for (int unsigned i = 0; i < held; i++) begin
        k = oldest + i;
        if (k >= cap)
          k -= cap;
        if (window[k] == price)
          continue;
        if (window[k] < price)
          is_min = 1'b0;
        else
          is_max = 1'b0;
      end
      if (is_min)
        res.verdict = VERDICT_MINIMA;
      else if (is_max)
        res.verdict = VERDICT_MAXIMA;
      else
        res.verdict = VERDICT_REGULAR;
      res.price = price;
      res.stamp = stamp;
      awaited_verdicts.push_back(res);
    endfunction

    function void check_verdict(input logic [VERDICT_BITS-1:0] verdict,
                                input logic signed [PRICE_BITS-1:0] price,
                                input logic signed [STAMP_BITS-1:0] stamp);
      judged_tick_t want;
      if (awaited_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual verdict %0d price %0d stamp %0d",
                 $time, verdict, price, stamp);
        return;
      end
      want = awaited_verdicts.pop_front();
      checked++;
      if (verdict !== want.verdict) begin
        errors++;
        $display("%0t: verdict mismatch: expected %0d, actual %0d", $time, want.verdict, verdict);
      end
      if (price !== want.price) begin
        errors++;
        $display("%0t: price_out mismatch: expected %0d, actual %0d", $time, want.price, price);
      end
      if (stamp !== want.stamp) begin
        errors++;
        $display("%0t: stamp_out mismatch: expected %0d, actual %0d", $time, want.stamp, stamp);
      end
      case (want.verdict)
        VERDICT_MINIMA: seen_minima++;
        VERDICT_MAXIMA: seen_maxima++;
        default:        seen_regular++;
      endcase
    endfunction
  endclass

endpackage

FILE: tb/tb_sliding_window_extremum_detector.sv
`timescale 1ns / 100ps
// testbench top: directed and random transactions into the extremum detector, every result checked
module tb_sliding_window_extremum_detector;
  import swx_pkg::*;
  import swx_scoreboard_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_GAP         = 12;
  localparam int SETTLE_CYCLES   = 40;    // room for the longest scan to finish
  localparam int HOLD_AFTER      = 400;   // results checked before the long output stall
  localparam int HOLD_CYCLES     = 500;
  localparam int WATCHDOG_LIMIT  = 3000;

  localparam logic signed [PRICE_BITS-1:0] PRICE_TOP    = {1'b0, {(PRICE_BITS-1){1'b1}}};
  localparam logic signed [PRICE_BITS-1:0] PRICE_BOTTOM = {1'b1, {(PRICE_BITS-1){1'b0}}};
  localparam logic signed [STAMP_BITS-1:0] STAMP_TOP    = {1'b0, {(STAMP_BITS-1){1'b1}}};
  localparam logic signed [STAMP_BITS-1:0] STAMP_BOTTOM = {1'b1, {(STAMP_BITS-1){1'b0}}};

  // shape of a run of random prices
  typedef enum int unsigned {
    STYLE_TIES,   // tiny alphabet, lots of equal prices
    STYLE_WALK,   // drifting walk, long rises and falls give extremes
    STYLE_WIDE    // full range with the odd extreme value
  } price_style_e;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic                         kind;
  logic signed [PRICE_BITS-1:0] price;
  logic signed [STAMP_BITS-1:0] stamp;
  logic                         out_valid;
  logic                         out_ready;
  logic [VERDICT_BITS-1:0]      verdict;
  logic signed [PRICE_BITS-1:0] price_out;
  logic signed [STAMP_BITS-1:0] stamp_out;
  logic                         cfg_we;
  logic [HALF_BITS-1:0]         cfg_data;

  swx_scoreboard board = new();

  // when set, that side never idles (stretches of back-to-back traffic)
  bit                           sender_eager;
  bit                           sink_eager;
  logic signed [PRICE_BITS-1:0] last_price;
  int                           drift;

  // half-window settings per random phase; zero checks the clamp, the last two are drawn
  logic [HALF_BITS-1:0] half_plan [RANDOM_PHASES] =
    '{4'd0, 4'd15, 4'd2, 4'd7, 4'd1, 4'd15, 4'd4, 4'd0, 4'd0};

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  sliding_window_extremum_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .price     (price),
    .stamp     (stamp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict),
    .price_out (price_out),
    .stamp_out (stamp_out),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // offer one transaction: optional idle gap, then hold valid and payload until taken
  // called and returns at a falling edge; valid is left high for a back-to-back follow-up
  task automatic send_transaction(input logic k,
                                  input logic signed [PRICE_BITS-1:0] p,
                                  input logic signed [STAMP_BITS-1:0] s);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    price    <= p;
    stamp    <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_transaction(k, p, s);
    @(negedge clk);
  endtask

  // drop valid, wait for every queued verdict, then let a verdict-less scan finish
  task automatic drain_window();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write only ever happens with the block idle
  task automatic write_half_window(input logic [HALF_BITS-1:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    board.set_half_window(value);
  endtask

  function automatic logic signed [STAMP_BITS-1:0] draw_stamp();
    if ($urandom_range(0, 9) != 0)
      return {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0:       return STAMP_TOP;
      1:       return STAMP_BOTTOM;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [PRICE_BITS-1:0] draw_price(input price_style_e style);
    logic signed [PRICE_BITS-1:0] p;
    case (style)
      STYLE_TIES: p = $signed($urandom_range(0, 6)) - 3;
      STYLE_WALK: p = last_price + drift + $signed($urandom_range(0, 4)) - 2;
      default: begin
        if ($urandom_range(0, 99) < 85)
          p = $urandom();
        else begin
          case ($urandom_range(0, 3))
            0:       p = PRICE_TOP;
            1:       p = PRICE_BOTTOM;
            2:       p = '0;
            default: p = '1;
          endcase
        end
      end
    endcase
    last_price = p;
    return p;
  endfunction

  // result side: random ready gaps, one long hold-off once enough results have passed
  initial begin : result_sink
    int unsigned gap;
    bit          held_off;
    held_off  = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && board.checked >= HOLD_AFTER) begin
        // long stall: the sender keeps offering, so the block backs up and drops in_ready
        held_off = 1'b1;
        gap      = HOLD_CYCLES;
      end else
        gap = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_verdict(verdict, price_out, stamp_out);
      @(negedge clk);
    end
  end

  // ends the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned  sent;
    int unsigned  run;
    price_style_e style;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_TICK;
    price        = '0;
    stamp        = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    sender_eager = 1'b0;
    sink_eager   = 1'b0;
    last_price   = '0;
    drift        = 0;
    half_plan[7] = HALF_BITS'($urandom_range(0, 15));
    half_plan[8] = HALF_BITS'($urandom_range(0, 15));
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset half window of 1: ring of 3, reporting from 2 prices
    send_transaction(KIND_TICK,  '0,            64'sd1);        // too few prices yet
    send_transaction(KIND_TICK,  '0,            64'sd2);        // all equal, minima
    send_transaction(KIND_TICK,  PRICE_TOP,     STAMP_TOP);     // maxima, ring now full
    send_transaction(KIND_TICK,  PRICE_BOTTOM,  STAMP_BOTTOM);  // minima, oldest overwritten
    send_transaction(KIND_TICK,  32'sd5,        '0);            // regular, oldest overwritten
    send_transaction(KIND_TICK,  32'sd5,        '1);            // ties skipped, maxima
    send_transaction(KIND_CLEAR, '1,            '1);            // clear, payload ignored
    send_transaction(KIND_TICK,  '1,            64'sd3);        // too few after clear
    send_transaction(KIND_TICK,  '1,            STAMP_TOP);     // all equal, minima
    send_transaction(KIND_CLEAR, '0,            '0);
    send_transaction(KIND_CLEAR, PRICE_BOTTOM,  STAMP_BOTTOM);  // clear on an empty ring
    send_transaction(KIND_TICK,  PRICE_BOTTOM,  64'sd4);
    send_transaction(KIND_TICK,  PRICE_TOP,     64'sd5);        // maxima across full range
    send_transaction(KIND_TICK,  PRICE_TOP,     64'sd6);        // maxima with a tie
    send_transaction(KIND_TICK,  '0,            64'sd7);        // minima once the bottom is overwritten
    send_transaction(KIND_TICK,  PRICE_BOTTOM,  64'sd8);        // minima after wrap
    drain_window();

    // random phases: each rewrite also empties the ring
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_half_window(half_plan[phase]);
      sender_eager = (phase % 3 == 1);
      sink_eager   = (phase % 3 == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        style = price_style_e'($urandom_range(0, 2));
        run   = $urandom_range(4, 40);
        // last run of a phase stops at the phase length
        if (run > ITEMS_PER_PHASE - sent)
          run = ITEMS_PER_PHASE - sent;
        drift = ($signed($urandom_range(0, 2)) - 1) * 7;
        repeat (run) begin
          // the odd clear breaks a run part way through
          if ($urandom_range(0, 99) < 3)
            send_transaction(KIND_CLEAR, $urandom(), draw_stamp());
          else
            send_transaction(KIND_TICK, draw_price(style), draw_stamp());
          sent++;
        end
      end
      drain_window();
    end

    $display("coverage: %0d ticks and %0d clears over half windows 1 to 15, zero writes clamped",
             board.ticks, board.clears);
    $display("coverage: %0d results checked (minima %0d, maxima %0d, regular %0d), one long stall",
             board.checked, board.seen_minima, board.seen_maxima, board.seen_regular);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
